@@ rtl/quaternion_slerp_top_assert.svh @@
// assertion helpers for the slerp block checker
`ifndef QUATERNION_SLERP_TOP_ASSERT_SVH
`define QUATERNION_SLERP_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define QS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/qs_pkg.sv @@
`timescale 1ns / 1ps

package qs_pkg;

  // fixed point layout of the quaternion components
  localparam int FRAC_BITS = 14;
  localparam int ONE_FRAC = 1 << FRAC_BITS;
  localparam int CQ_W = FRAC_BITS;
  // shift of the squared Q14 cosine radicand, so that its root comes out in Q30
  localparam int SQ_SH = 2 * (30 - FRAC_BITS);
  localparam int U_W = 2 * FRAC_BITS + 2;

  // angle and weight datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CW = 34;
  localparam int ROOT_W = 31;
  localparam int WT_W = 31;
  localparam int DIV_BITS = 30;

  localparam logic [15:0] BLEND_ONE = 16'd32768;
  localparam logic signed [CW-1:0] GAIN_INV = 34'sh026DD3B6A;
  localparam logic [WT_W-1:0] ONE_Q30 = 31'h40000000;

  // register map, word index
  localparam logic REG_LERP_THR = 1'b0;
  localparam logic [14:0] THR_RESET = 15'd16;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
    logic [15:0]        blend;
  } qs_raw_t;

  // quaternion pair after shortest-arc correction
  typedef struct packed {
    logic signed [16:0] a_x;
    logic signed [16:0] a_y;
    logic signed [16:0] a_z;
    logic signed [16:0] a_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] b_w;
  } qs_vec_t;

  // arctangent of 2^-i, Q30
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      5'd24:   v = 34'sh00000003F;
      5'd25:   v = 34'sh00000001F;
      5'd26:   v = 34'sh00000000F;
      5'd27:   v = 34'sh000000007;
      5'd28:   v = 34'sh000000003;
      5'd29:   v = 34'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/qs_if.sv @@
`timescale 1ns / 1ps

// request channel: two quaternions and the blend factor
interface qs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] a_x;
  logic signed [15:0] a_y;
  logic signed [15:0] a_z;
  logic signed [15:0] a_w;
  logic signed [15:0] b_x;
  logic signed [15:0] b_y;
  logic signed [15:0] b_z;
  logic signed [15:0] b_w;
  logic [15:0]        blend;

  modport source (
    output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend,
    output ready
  );
endinterface

// result channel: interpolated quaternion
interface qs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_w;

  modport source (
    output valid, out_x, out_y, out_z, out_w,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w,
    output ready
  );
endinterface

@@ rtl/quaternion_slerp_top.sv @@
`timescale 1ns / 1ps

// Quaternion slerp with linear fallback, Q2.14 components, Q1.15 blend.
// in_ch carries quaternions a and b and the blend factor; out_ch returns the
// interpolated quaternion, each component rounded and saturated.
// Channels use valid/ready; a transfer happens when both are high.
// The cfg_ APB port holds lerp_threshold at word 0 (byte address 0); at or
// below that value of one minus the cosine, linear weights are used.
// A request passes the dot product, the square root (33 stages with the
// squaring), the angle CORDIC (30), the angle split, the three parallel
// sine CORDICs (30), the weight dividers (31) and the mixing stages. One
// request is taken every cycle unless the output stalls.
// All stages advance together: while a result waits with out_ch.ready low
// the whole pipeline holds and in_ch.ready is low; nothing is dropped.
// Synchronous reset clears all valid bits and sets lerp_threshold to 16.

module quaternion_slerp_top (
  input  logic        clk,
  input  logic        rst_n,
  qs_in_if.sink       in_ch,
  qs_out_if.source    out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int LAT = 132;
  localparam int CW  = qs_pkg::CW;
  localparam int WW  = qs_pkg::WT_W;
  localparam int VW  = $bits(qs_pkg::qs_vec_t);

  logic [LAT-1:0]  valid_r;
  logic            en;
  logic [14:0]     thr_r;
  qs_pkg::qs_raw_t raw;

  qs_pkg::qs_vec_t vec3;
  logic [15:0]     t3;
  logic [qs_pkg::CQ_W-1:0] cq3;
  logic            sph3;
  logic [qs_pkg::ROOT_W-1:0] root36;
  logic [qs_pkg::CQ_W-1:0]   cq36;
  logic signed [CW-1:0] ang66;
  logic [15:0]          t66;
  logic signed [CW+16:0] th_prod;
  logic signed [CW-1:0] ang67_r;
  logic signed [CW-1:0] th1_67_r;
  logic signed [CW-1:0] ang68_r;
  logic signed [CW-1:0] th0_68_r;
  logic signed [CW-1:0] th1_68_r;
  logic signed [CW-1:0] sin_ang98;
  logic signed [CW-1:0] s0_98;
  logic signed [CW-1:0] s1_98;
  logic [WW-1:0]        w0_div;
  logic [WW-1:0]        w1_div;
  logic                 sinpos129;
  logic                 sph129;
  logic [15:0]          t129;
  logic [VW-1:0]        vec130_bits;
  qs_pkg::qs_vec_t      vec130;
  logic [WW-1:0]        w0_r;
  logic [WW-1:0]        w1_r;
  logic [WW-1:0]        w_lin;
  logic signed [16:0]   av [4];
  logic signed [15:0]   bv [4];
  logic signed [48:0]   pa_r [4];
  logic signed [48:0]   pb_r [4];
  logic signed [15:0]   o_r  [4];

  function automatic logic signed [15:0] round_sat(input logic signed [49:0] r);
    logic signed [19:0] s;
    s = 20'((r + 50'sd536870912) >>> 30);
    if (s > 20'sd32767) begin
      return 16'sd32767;
    end else if (s < -20'sd32768) begin
      return -16'sd32768;
    end
    return s[15:0];
  endfunction

  // global advance: all stages move unless a finished result is held back
  assign en          = !valid_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAT-2:0], in_ch.valid};
    end
  end

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == qs_pkg::REG_LERP_THR) ? {17'b0, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= qs_pkg::THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == qs_pkg::REG_LERP_THR) begin
      thr_r <= cfg_pwdata[14:0];
    end
  end

  always_comb begin
    raw.a_x   = in_ch.a_x;
    raw.a_y   = in_ch.a_y;
    raw.a_z   = in_ch.a_z;
    raw.a_w   = in_ch.a_w;
    raw.b_x   = in_ch.b_x;
    raw.b_y   = in_ch.b_y;
    raw.b_z   = in_ch.b_z;
    raw.b_w   = in_ch.b_w;
    raw.blend = in_ch.blend;
  end

  // dot product, shortest arc, lerp decision
  qs_front u_front (
    .clk   (clk),
    .en    (en),
    .raw_i (raw),
    .thr_i (thr_r),
    .vec_o (vec3),
    .t_o   (t3),
    .cq_o  (cq3),
    .sph_o (sph3)
  );

  // sine of the arc from the cosine
  qs_isqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .cq_i   (cq3),
    .root_o (root36)
  );

  qs_delay #(.W(qs_pkg::CQ_W), .D(33)) u_dly_cq (
    .clk (clk), .en (en), .d_i (cq3), .q_o (cq36)
  );

  // arc angle
  qs_cordic u_angle (
    .clk      (clk),
    .en       (en),
    .mode_vec (1'b1),
    .x_i      ($signed(CW'(cq36) << (30 - qs_pkg::FRAC_BITS))),
    .y_i      ($signed(CW'(root36))),
    .z_i      ('0),
    .y_o      (),
    .z_o      (ang66)
  );

  qs_delay #(.W(16), .D(63)) u_dly_t0 (
    .clk (clk), .en (en), .d_i (t3), .q_o (t66)
  );

  // split the angle by the blend factor
  assign th_prod = ang66 * $signed({1'b0, t66});

  always_ff @(posedge clk) begin
    if (en) begin
      ang67_r  <= ang66;
      th1_67_r <= CW'(th_prod >>> 15);
      ang68_r  <= ang67_r;
      th1_68_r <= th1_67_r;
      th0_68_r <= ang67_r - th1_67_r;
    end
  end

  // three sines side by side
  qs_cordic u_sin_ang (
    .clk (clk), .en (en), .mode_vec (1'b0),
    .x_i (qs_pkg::GAIN_INV), .y_i ('0), .z_i (ang68_r),
    .y_o (sin_ang98), .z_o ()
  );

  qs_cordic u_sin_0 (
    .clk (clk), .en (en), .mode_vec (1'b0),
    .x_i (qs_pkg::GAIN_INV), .y_i ('0), .z_i (th0_68_r),
    .y_o (s0_98), .z_o ()
  );

  qs_cordic u_sin_1 (
    .clk (clk), .en (en), .mode_vec (1'b0),
    .x_i (qs_pkg::GAIN_INV), .y_i ('0), .z_i (th1_68_r),
    .y_o (s1_98), .z_o ()
  );

  // spherical weights
  qs_div u_div_0 (
    .clk (clk), .en (en), .num_i (s0_98), .den_i (sin_ang98), .q_o (w0_div)
  );

  qs_div u_div_1 (
    .clk (clk), .en (en), .num_i (s1_98), .den_i (sin_ang98), .q_o (w1_div)
  );

  qs_delay #(.W(1), .D(31)) u_dly_sinpos (
    .clk (clk), .en (en), .d_i (sin_ang98 > 0), .q_o (sinpos129)
  );

  qs_delay #(.W(1), .D(126)) u_dly_sph (
    .clk (clk), .en (en), .d_i (sph3), .q_o (sph129)
  );

  qs_delay #(.W(16), .D(63)) u_dly_t1 (
    .clk (clk), .en (en), .d_i (t66), .q_o (t129)
  );

  qs_delay #(.W(VW), .D(127)) u_dly_vec (
    .clk (clk), .en (en), .d_i (vec3), .q_o (vec130_bits)
  );

  assign vec130 = qs_pkg::qs_vec_t'(vec130_bits);
  assign w_lin  = WW'({t129, 15'b0});

  // weight select: spherical unless lerp was chosen or the arc sine failed
  always_ff @(posedge clk) begin
    if (en) begin
      if (sph129 && sinpos129) begin
        w0_r <= w0_div;
        w1_r <= w1_div;
      end else begin
        w0_r <= qs_pkg::ONE_Q30 - w_lin;
        w1_r <= w_lin;
      end
    end
  end

  always_comb begin
    av[0] = vec130.a_x;
    av[1] = vec130.a_y;
    av[2] = vec130.a_z;
    av[3] = vec130.a_w;
    bv[0] = vec130.b_x;
    bv[1] = vec130.b_y;
    bv[2] = vec130.b_z;
    bv[3] = vec130.b_w;
  end

  // weighted components, then round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        pa_r[j] <= $signed({1'b0, w0_r}) * av[j];
        pb_r[j] <= $signed({1'b0, w1_r}) * bv[j];
        o_r[j]  <= round_sat(50'(pa_r[j]) + 50'(pb_r[j]));
      end
    end
  end

  assign out_ch.valid = valid_r[LAT-1];
  assign out_ch.out_x = o_r[0];
  assign out_ch.out_y = o_r[1];
  assign out_ch.out_z = o_r[2];
  assign out_ch.out_w = o_r[3];

endmodule

@@ rtl/qs_delay.sv @@
`timescale 1ns / 1ps

module qs_delay #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_r [D];

  // plain shift line, frozen while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  assign q_o = sr_r[D-1];

endmodule

@@ rtl/qs_front.sv @@
`timescale 1ns / 1ps

module qs_front (
  input  logic             clk,
  input  logic             en,
  input  qs_pkg::qs_raw_t  raw_i,
  input  logic [14:0]      thr_i,
  output qs_pkg::qs_vec_t  vec_o,
  output logic [15:0]      t_o,
  output logic [qs_pkg::CQ_W-1:0] cq_o,
  output logic             sph_o
);

  qs_pkg::qs_raw_t    s1_r;
  qs_pkg::qs_raw_t    s2_r;
  logic signed [31:0] p1_r [4];
  logic signed [33:0] dot2_r;
  qs_pkg::qs_vec_t    vec3_r;
  logic [15:0]        t3_r;
  logic [qs_pkg::CQ_W-1:0] cq3_r;
  logic               sph3_r;

  logic               neg;
  logic [33:0]        dabs;
  logic [33:0]        cq_full;
  logic signed [35:0] onem;

  // stage 1: component products, blend clipped to one
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r       <= {raw_i.a_x, raw_i.a_y, raw_i.a_z, raw_i.a_w,
                     raw_i.b_x, raw_i.b_y, raw_i.b_z, raw_i.b_w,
                     (raw_i.blend > qs_pkg::BLEND_ONE) ? qs_pkg::BLEND_ONE : raw_i.blend};
      p1_r[0]    <= raw_i.a_x * raw_i.b_x;
      p1_r[1]    <= raw_i.a_y * raw_i.b_y;
      p1_r[2]    <= raw_i.a_z * raw_i.b_z;
      p1_r[3]    <= raw_i.a_w * raw_i.b_w;
    end
  end

  // stage 2: dot product
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= s1_r;
      dot2_r <= 34'(p1_r[0]) + 34'(p1_r[1]) + 34'(p1_r[2]) + 34'(p1_r[3]);
    end
  end

  // shortest arc and lerp decision
  always_comb begin
    neg     = dot2_r[33];
    dabs    = neg ? 34'(-dot2_r) : 34'(dot2_r);
    cq_full = dabs >> qs_pkg::FRAC_BITS;
    onem    = $signed(36'(qs_pkg::ONE_FRAC)) - $signed({2'b00, cq_full});
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en) begin
      vec3_r.a_x <= neg ? -$signed(17'(s2_r.a_x)) : $signed(17'(s2_r.a_x));
      vec3_r.a_y <= neg ? -$signed(17'(s2_r.a_y)) : $signed(17'(s2_r.a_y));
      vec3_r.a_z <= neg ? -$signed(17'(s2_r.a_z)) : $signed(17'(s2_r.a_z));
      vec3_r.a_w <= neg ? -$signed(17'(s2_r.a_w)) : $signed(17'(s2_r.a_w));
      vec3_r.b_x <= s2_r.b_x;
      vec3_r.b_y <= s2_r.b_y;
      vec3_r.b_z <= s2_r.b_z;
      vec3_r.b_w <= s2_r.b_w;
      t3_r       <= s2_r.blend;
      cq3_r      <= cq_full[qs_pkg::CQ_W-1:0];
      sph3_r     <= onem > $signed({21'b0, thr_i});
    end
  end

  assign vec_o = vec3_r;
  assign t_o   = t3_r;
  assign cq_o  = cq3_r;
  assign sph_o = sph3_r;

endmodule

@@ rtl/qs_isqrt.sv @@
`timescale 1ns / 1ps

module qs_isqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [qs_pkg::CQ_W-1:0]   cq_i,
  output logic [qs_pkg::ROOT_W-1:0] root_o
);

  localparam int RW  = qs_pkg::ROOT_W;
  localparam int UW  = qs_pkg::U_W;
  localparam int RDW = qs_pkg::U_W + qs_pkg::SQ_SH;

  logic [2*qs_pkg::CQ_W-1:0] sq_r;
  logic [UW-1:0]             u_r;
  logic [33:0]               rem_r  [RW];
  logic [RW-1:0]             root_r [RW];
  logic [UW-1:0]             uu_r   [RW];
  logic [33:0]               rem_nxt  [RW];
  logic [RW-1:0]             root_nxt [RW];
  logic [UW-1:0]             uu_nxt   [RW];

  // square of the cosine, then one minus it
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= (2*qs_pkg::CQ_W)'(cq_i) * (2*qs_pkg::CQ_W)'(cq_i);
      u_r  <= {2'b01, {(2*qs_pkg::CQ_W){1'b0}}} - UW'(sq_r);
    end
  end

  // one root bit per stage, most significant first
  always_comb begin
    logic [33:0]    rem_in;
    logic [RW-1:0]  root_in;
    logic [UW-1:0]  u_in;
    logic [RDW-1:0] rad;
    logic [33:0]    pre;
    logic [33:0]    trial;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        u_in    = u_r;
      end else begin
        rem_in  = rem_r[k-1];
        root_in = root_r[k-1];
        u_in    = uu_r[k-1];
      end
      rad   = {u_in, {qs_pkg::SQ_SH{1'b0}}};
      pre   = {rem_in[31:0], rad[2*(RW-1-k) +: 2]};
      trial = {1'b0, root_in, 2'b01};
      if (pre >= trial) begin
        rem_nxt[k]  = pre - trial;
        root_nxt[k] = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = pre;
        root_nxt[k] = {root_in[RW-2:0], 1'b0};
      end
      uu_nxt[k] = u_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        uu_r[k]   <= uu_nxt[k];
      end
    end
  end

  assign root_o = root_r[RW-1];

endmodule

@@ rtl/qs_cordic.sv @@
`timescale 1ns / 1ps

module qs_cordic (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         mode_vec,
  input  logic signed [qs_pkg::CW-1:0] x_i,
  input  logic signed [qs_pkg::CW-1:0] y_i,
  input  logic signed [qs_pkg::CW-1:0] z_i,
  output logic signed [qs_pkg::CW-1:0] y_o,
  output logic signed [qs_pkg::CW-1:0] z_o
);

  localparam int N  = qs_pkg::CORDIC_STEPS;
  localparam int CW = qs_pkg::CW;

  logic signed [CW-1:0] x_r [N];
  logic signed [CW-1:0] y_r [N];
  logic signed [CW-1:0] z_r [N];
  logic signed [CW-1:0] x_nxt [N];
  logic signed [CW-1:0] y_nxt [N];
  logic signed [CW-1:0] z_nxt [N];

  // one micro-rotation per stage; vectoring drives y to zero, rotation drives z
  always_comb begin
    logic signed [CW-1:0] xin;
    logic signed [CW-1:0] yin;
    logic signed [CW-1:0] zin;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    logic                 up;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        xin = x_i;
        yin = y_i;
        zin = z_i;
      end else begin
        xin = x_r[k-1];
        yin = y_r[k-1];
        zin = z_r[k-1];
      end
      dx = yin >>> k;
      dy = xin >>> k;
      at = qs_pkg::atan_q30(5'(k));
      up = mode_vec ? !yin[CW-1] : zin[CW-1];
      if (up) begin
        x_nxt[k] = xin + dx;
        y_nxt[k] = yin - dy;
        z_nxt[k] = zin + at;
      end else begin
        x_nxt[k] = xin - dx;
        y_nxt[k] = yin + dy;
        z_nxt[k] = zin - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
    end
  end

  assign y_o = y_r[N-1];
  assign z_o = z_r[N-1];

endmodule

@@ rtl/qs_div.sv @@
`timescale 1ns / 1ps

module qs_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [qs_pkg::CW-1:0] num_i,
  input  logic signed [qs_pkg::CW-1:0] den_i,
  output logic [qs_pkg::WT_W-1:0]      q_o
);

  localparam int NB = qs_pkg::DIV_BITS;

  logic        hi_r  [NB+1];
  logic        lo_r  [NB+1];
  logic [32:0] rem_r [NB+1];
  logic [32:0] den_r [NB+1];
  logic [NB-1:0] q_r [NB+1];
  logic [32:0]   rem_nxt [NB+1];
  logic [NB-1:0] q_nxt   [NB+1];

  // restoring division, one quotient bit per stage; stage 0 sorts out clamping
  always_comb begin
    logic [32:0] pre;
    rem_nxt[0] = num_i[32:0];
    q_nxt[0]   = '0;
    for (int k = 1; k <= NB; k++) begin
      pre = {rem_r[k-1][31:0], 1'b0};
      if (pre >= den_r[k-1]) begin
        rem_nxt[k] = pre - den_r[k-1];
        q_nxt[k]   = {q_r[k-1][NB-2:0], 1'b1};
      end else begin
        rem_nxt[k] = pre;
        q_nxt[k]   = {q_r[k-1][NB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r[0]  <= num_i >= den_i;
      lo_r[0]  <= num_i <= 0;
      den_r[0] <= den_i[32:0];
      rem_r[0] <= rem_nxt[0];
      q_r[0]   <= q_nxt[0];
      for (int k = 1; k <= NB; k++) begin
        hi_r[k]  <= hi_r[k-1];
        lo_r[k]  <= lo_r[k-1];
        den_r[k] <= den_r[k-1];
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  // weight clamped to 0..1
  assign q_o = hi_r[NB] ? qs_pkg::ONE_Q30 :
               lo_r[NB] ? '0 : {1'b0, q_r[NB]};

endmodule

@@ rtl/qs_check.sv @@
`timescale 1ns / 1ps

`include "quaternion_slerp_top_assert.svh"

module qs_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [15:0] out_z,
  input logic [15:0] out_w,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata
);

  // a held result stays offered
  `QS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result lost while stalled")

  // a held result keeps its value
  `QS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(out_w), "result changed while stalled")

  // a stalled result means no new request is taken
  `QS_ASSERT_SAME(a_backpressure, out_valid && !out_ready, !in_ready, "request taken while output stalled")

  // a request is only refused while a result is held back
  `QS_ASSERT_SAME(a_stall_cause, in_valid && !in_ready, out_valid && !out_ready, "request refused without a stall")

  // threshold write reads back
  `QS_ASSERT_NEXT(a_cfg_readback, cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2], cfg_paddr[2] || (cfg_prdata[14:0] == $past(cfg_pwdata[14:0]) && cfg_prdata[31:15] == 17'b0), "threshold readback mismatch")

endmodule

bind quaternion_slerp_top qs_check u_qs_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_x       (out_ch.out_x),
  .out_y       (out_ch.out_y),
  .out_z       (out_ch.out_z),
  .out_w       (out_ch.out_w),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
